// ===== hw/rtl/block_table_pool_allocator_core_macros.svh =====
// Assertion macros used by the allocator core.
`ifndef BLOCK_TABLE_POOL_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_TABLE_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BTPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BTPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/btpa_pkg.sv =====
// Shared constants and codes of the block table pool allocator.
package btpa_pkg;

  localparam int BANKS_DEF         = 5;
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int BLOCK_BYTES_DEF   = 32;

  localparam int ENTRY_W  = 9;
  localparam int REQ_W    = 2;
  localparam int BANK_W   = 3;
  localparam int BYTES_W  = 14;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int ROFF_W   = 13;
  localparam int PCT_W    = 7;

  localparam int PCT_SCALE = 100;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_USAGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNINIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

endpackage

// ===== hw/rtl/btpa_div.sv =====
// Division by a constant through a reciprocal multiply, with a registered quotient.
module btpa_div #(
  parameter int NW      = 16,
  parameter int DIVISOR = 32
) (
  input  logic          clk,
  input  logic          load,
  input  logic [NW-1:0] dividend,
  output logic [NW-1:0] quotient
);

  // With the shift set to NW plus the rounded-up log2 of the divisor and the
  // reciprocal rounded up, the shifted product is the exact quotient for every
  // NW-bit dividend.
  localparam int     SH    = NW + $clog2(DIVISOR);
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
                             longint'(DIVISOR);
  localparam int     MW    = NW + 1;
  localparam int     PW    = NW + MW;
  localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

  logic [PW-1:0] prod;
  logic [NW-1:0] quotient_r, quotient_nxt;

  assign prod         = PW'(dividend) * PW'(RECIP_V);
  assign quotient_nxt = NW'(prod[PW-1:SH]);

  always_ff @(posedge clk) begin
    if (load) begin
      quotient_r <= quotient_nxt;
    end
  end

  assign quotient = quotient_r;

endmodule

// ===== hw/rtl/block_table_pool_allocator_core.sv =====
// Top level of the block table pool allocator: table memory, request sequencer, results.
//
// Requests arrive on the in_ channel (valid/ready), one word per request, and each
// gives exactly one result word on the out_ channel (valid/ready). A request is taken
// only while the sequencer is idle; its result sits in an output register, so the next
// request can be taken while that result still waits for out_ready.
// Steps per request, from acceptance to the result register (T entries per bank):
//   allocate : the top-down scan at one table read per cycle, then one cycle per block
//              marked; size zero or a bad bank goes straight to the result.
//   free     : the block index by reciprocal multiply, the table read and the
//              length, then one cycle per entry cleared; a bank not yet used or an
//              offset past the pool goes straight to the result.
//   usage    : the counting scan followed by the percentage multiply.
// Once the result register is loaded, the sequencer is back in idle and can take the next request.
// The table memory is read or written one entry per cycle.
// After reset all BANKS * T entries of the table memory are swept to zero, one entry per
// cycle; in_ready stays low until the sweep ends.
// A stalled receiver holds the result; a finished request then waits for the output
// register to free before the block becomes ready again.
module block_table_pool_allocator_core #(
  parameter int BANKS         = btpa_pkg::BANKS_DEF,
  parameter int TABLE_ENTRIES = btpa_pkg::TABLE_ENTRIES_DEF,
  parameter int BLOCK_BYTES   = btpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [btpa_pkg::REQ_W-1:0]      in_req_type,
  input  logic [btpa_pkg::BANK_W-1:0]     in_bank,
  input  logic [btpa_pkg::BYTES_W-1:0]    in_alloc_bytes,
  input  logic [btpa_pkg::OFFSET_W-1:0]   in_byte_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [btpa_pkg::STATUS_W-1:0]   out_status,
  output logic [btpa_pkg::ROFF_W-1:0]     out_result_offset,
  output logic [btpa_pkg::PCT_W-1:0]      out_used_percent
);

`include "block_table_pool_allocator_core_macros.svh"

  localparam int EntW  = btpa_pkg::ENTRY_W;
  localparam int RoW   = btpa_pkg::ROFF_W;
  localparam int PctW  = btpa_pkg::PCT_W;
  localparam int BytW  = btpa_pkg::BYTES_W;
  localparam int OffW  = btpa_pkg::OFFSET_W;
  localparam int DEPTH = BANKS * TABLE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(TABLE_ENTRIES);
  localparam int UW    = $clog2(TABLE_ENTRIES + 1);
  localparam int BKW   = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int RBW   = $clog2(TABLE_ENTRIES * BLOCK_BYTES + 1);
  localparam int CW    = (RBW > BytW) ? RBW : BytW;
  localparam int PW    = (RBW > RoW) ? RBW : RoW;
  localparam int CNW   = (UW > EntW) ? UW : EntW;
  localparam int UDW   = $clog2(TABLE_ENTRIES * btpa_pkg::PCT_SCALE + 1);
  localparam int OWW   = 1 + btpa_pkg::STATUS_W + RoW + PctW;
  localparam int POOL_BYTES = TABLE_ENTRIES * BLOCK_BYTES;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_ASCAN  = 12'b0000_0000_0100,
    S_MARK   = 12'b0000_0000_1000,
    S_USCAN  = 12'b0000_0001_0000,
    S_USTART = 12'b0000_0010_0000,
    S_UDIV   = 12'b0000_0100_0000,
    S_FDIV   = 12'b0000_1000_0000,
    S_FRD    = 12'b0001_0000_0000,
    S_FLEN   = 12'b0010_0000_0000,
    S_FCLR   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [BANKS-1:0] ready_r, ready_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [BytW-1:0] bytes_r, bytes_nxt;
  logic [EW-1:0]   rd_e_r, rd_e_nxt;
  logic            issue_r, issue_nxt;
  logic            pv_r, pv_nxt;
  logic [EW-1:0]   pe_r, pe_nxt;
  logic [UW-1:0]   run_r, run_nxt;
  logic [RBW-1:0]  rb_r, rb_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [EW-1:0]   wr_e_r, wr_e_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic [EntW-1:0] mk_val_r, mk_val_nxt;

  logic [btpa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [RoW-1:0]                res_off_r, res_off_nxt;
  logic [PctW-1:0]               res_pct_r, res_pct_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [btpa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [RoW-1:0]                out_off_r, out_off_nxt;
  logic [PctW-1:0]               out_pct_r, out_pct_nxt;

  // Table memory: one write port, one registered read port.
  logic [EntW-1:0] mem [DEPTH];
  logic [EntW-1:0] rdata_r;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [EntW-1:0] wdata;
  logic [AW-1:0]   raddr;

  logic [OffW-1:0] blk_idx;
  logic            pct_load;
  logic [UDW-1:0]  pct_num;
  logic [UDW-1:0]  pct_quot;

  logic            accept;
  logic            bank_ok;
  logic            bank_rdy;
  logic            entry_free;
  logic [UW-1:0]   run_inc;
  logic [RBW-1:0]  rb_inc;
  logic            hit;
  logic [PW-1:0]   found_off;

  logic            usage_busy;
  logic            bank_claim;
  logic [BKW-1:0]  bank_sel;
  logic            out_stall;
  logic [OWW-1:0]  out_word;

  assign accept     = in_valid && in_ready;
  assign bank_ok    = 32'(in_bank) < BANKS;
  assign bank_rdy   = ready_r[in_bank[BKW-1:0]];
  assign entry_free = rdata_r == '0;
  assign run_inc    = run_r + UW'(1);
  assign rb_inc     = rb_r + RBW'(BLOCK_BYTES);
  // The run reaches the needed length exactly when its byte span first covers the request.
  assign hit        = entry_free && (CW'(rb_inc) >= CW'(bytes_r));
  assign found_off  = PW'(pe_r) * PW'(BLOCK_BYTES);

  assign raddr = base_r + AW'(rd_e_r);

  // The block index of every accepted offset is ready in the cycle after acceptance.
  btpa_div #(
    .NW      (OffW),
    .DIVISOR (BLOCK_BYTES)
  ) u_blk_div (
    .clk      (clk),
    .load     (accept),
    .dividend (in_byte_offset),
    .quotient (blk_idx)
  );

  assign pct_load = state_r == S_USTART;
  assign pct_num  = UDW'(used_r) * UDW'(btpa_pkg::PCT_SCALE);

  btpa_div #(
    .NW      (UDW),
    .DIVISOR (TABLE_ENTRIES)
  ) u_pct_div (
    .clk      (clk),
    .load     (pct_load),
    .dividend (pct_num),
    .quotient (pct_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    ready_nxt      = ready_r;
    base_nxt       = base_r;
    bytes_nxt      = bytes_r;
    rd_e_nxt       = rd_e_r;
    issue_nxt      = issue_r;
    pv_nxt         = pv_r;
    pe_nxt         = pe_r;
    run_nxt        = run_r;
    rb_nxt         = rb_r;
    used_nxt       = used_r;
    wr_e_nxt       = wr_e_r;
    cnt_nxt        = cnt_r;
    mk_val_nxt     = mk_val_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_pct_nxt    = res_pct_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_pct_nxt    = out_pct_r;
    mem_we         = 1'b0;
    waddr          = base_r + AW'(wr_e_r);
    wdata          = '0;
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        waddr        = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_nxt = btpa_pkg::ST_OK;
          res_off_nxt    = '0;
          res_pct_nxt    = '0;
          base_nxt       = AW'(32'(in_bank) * TABLE_ENTRIES);
          bytes_nxt      = in_alloc_bytes;
          rd_e_nxt       = EW'(TABLE_ENTRIES - 1);
          issue_nxt      = 1'b1;
          pv_nxt         = 1'b0;
          run_nxt        = '0;
          rb_nxt         = '0;
          used_nxt       = '0;
          state_nxt      = S_DONE;
          if (!bank_ok) begin
            res_status_nxt = btpa_pkg::ST_RANGE;
          end else begin
            case (in_req_type)
              btpa_pkg::REQ_ALLOC: begin
                ready_nxt[in_bank[BKW-1:0]] = 1'b1;
                if (in_alloc_bytes == '0) begin
                  res_status_nxt = btpa_pkg::ST_FAIL;
                end else begin
                  state_nxt = S_ASCAN;
                end
              end
              btpa_pkg::REQ_FREE: begin
                if (!bank_rdy) begin
                  // A never-used bank is already all zero, so marking it ready suffices.
                  ready_nxt[in_bank[BKW-1:0]] = 1'b1;
                  res_status_nxt = btpa_pkg::ST_UNINIT;
                end else if (32'(in_byte_offset) >= POOL_BYTES) begin
                  res_status_nxt = btpa_pkg::ST_RANGE;
                end else begin
                  state_nxt = S_FDIV;
                end
              end
              btpa_pkg::REQ_USAGE: begin
                state_nxt = S_USCAN;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_ASCAN: begin
        // Reads are issued one per cycle; each word is judged the cycle after its read.
        pv_nxt = issue_r;
        pe_nxt = rd_e_r;
        if (issue_r) begin
          rd_e_nxt = rd_e_r - EW'(1);
          if (rd_e_r == '0) begin
            issue_nxt = 1'b0;
          end
        end
        if (pv_r) begin
          run_nxt = entry_free ? run_inc : '0;
          rb_nxt  = entry_free ? rb_inc : '0;
          if (hit) begin
            wr_e_nxt    = pe_r;
            cnt_nxt     = CNW'(run_inc);
            mk_val_nxt  = EntW'(run_inc);
            res_off_nxt = found_off[RoW-1:0];
            issue_nxt   = 1'b0;
            pv_nxt      = 1'b0;
            state_nxt   = S_MARK;
          end else if (pe_r == '0) begin
            res_status_nxt = btpa_pkg::ST_FAIL;
            issue_nxt      = 1'b0;
            pv_nxt         = 1'b0;
            state_nxt      = S_DONE;
          end
        end
      end

      S_MARK: begin
        mem_we   = 1'b1;
        wdata    = mk_val_r;
        wr_e_nxt = wr_e_r + EW'(1);
        cnt_nxt  = cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          state_nxt = S_DONE;
        end
      end

      S_USCAN: begin
        pv_nxt = issue_r;
        pe_nxt = rd_e_r;
        if (issue_r) begin
          rd_e_nxt = rd_e_r - EW'(1);
          if (rd_e_r == '0) begin
            issue_nxt = 1'b0;
          end
        end
        if (pv_r) begin
          used_nxt = used_r + UW'(!entry_free);
          if (pe_r == '0) begin
            pv_nxt    = 1'b0;
            state_nxt = S_USTART;
          end
        end
      end

      S_USTART: begin
        state_nxt = S_UDIV;
      end

      S_UDIV: begin
        res_pct_nxt = PctW'(pct_quot);
        state_nxt   = S_DONE;
      end

      S_FDIV: begin
        rd_e_nxt  = EW'(blk_idx);
        state_nxt = S_FRD;
      end

      S_FRD: begin
        state_nxt = S_FLEN;
      end

      S_FLEN: begin
        wr_e_nxt = rd_e_r;
        cnt_nxt  = CNW'(rdata_r);
        if (rdata_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FCLR;
        end
      end

      S_FCLR: begin
        // Clearing runs for the recorded length but never past the last entry.
        mem_we   = 1'b1;
        wdata    = '0;
        wr_e_nxt = wr_e_r + EW'(1);
        cnt_nxt  = cnt_r - CNW'(1);
        if ((cnt_r == CNW'(1)) || (wr_e_r == EW'(TABLE_ENTRIES - 1))) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_pct_nxt    = res_pct_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      ready_r     <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ready_r     <= ready_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    bytes_r      <= bytes_nxt;
    rd_e_r       <= rd_e_nxt;
    pe_r         <= pe_nxt;
    run_r        <= run_nxt;
    rb_r         <= rb_nxt;
    used_r       <= used_nxt;
    wr_e_r       <= wr_e_nxt;
    cnt_r        <= cnt_nxt;
    mk_val_r     <= mk_val_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_pct_r    <= res_pct_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_pct_r    <= out_pct_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_offset = out_off_r;
  assign out_used_percent  = out_pct_r;

  assign usage_busy = (state_r == S_USCAN) || (state_r == S_USTART) || (state_r == S_UDIV);
  assign bank_sel   = in_bank[BKW-1:0];
  assign bank_claim = accept && bank_ok &&
                      ((in_req_type == btpa_pkg::REQ_ALLOC) ||
                       (in_req_type == btpa_pkg::REQ_FREE));
  assign out_stall  = out_valid_r && !out_ready;
  assign out_word   = {out_valid_r, out_status_r, out_off_r, out_pct_r};

  `BTPA_ASSERT_NOW(a_usage_no_write, usage_busy, !mem_we, "table written during a usage query")
  `BTPA_ASSERT_NEXT(a_bank_marked_ready, bank_claim, ready_r[$past(bank_sel)], "bank left unready")
  `BTPA_ASSERT_NEXT(a_out_held, out_stall, $stable(out_word), "result word changed while stalled")

endmodule
